// ===== rtl/local_alignment_score_traceback_assert.svh =====
// Assertion macros shared by the alignment engine.
`ifndef LOCAL_ALIGNMENT_SCORE_TRACEBACK_ASSERT_SVH
`define LOCAL_ALIGNMENT_SCORE_TRACEBACK_ASSERT_SVH

// Same-cycle implication, disabled while reset is high.
`define LSAT_ASSERT_NOW(lbl, ante, cons) \
   lbl: assert property (@(posedge clock) disable iff (reset) (ante) |-> (cons)) \
      else $error("alignment engine check failed");

// Next-cycle implication, disabled while reset is high.
`define LSAT_ASSERT_NEXT(lbl, ante, cons) \
   lbl: assert property (@(posedge clock) disable iff (reset) (ante) |=> (cons)) \
      else $error("alignment engine check failed");

`endif

// ===== rtl/lsat_pkg.sv =====
// Package: sizes, codes and controller/datapath interface types.
`timescale 1ns / 1ps
`default_nettype none
package lsat_pkg;
   localparam int MAX_SEQ_LEN = 256;
   localparam int DIM         = MAX_SEQ_LEN + 1;
   localparam int MAT_DEPTH   = DIM * DIM;
   localparam int MAT_AW      = $clog2(MAT_DEPTH);
   localparam int SEQ_AW      = $clog2(MAX_SEQ_LEN);
   localparam int LEN_W       = $clog2(MAX_SEQ_LEN + 1);
   localparam int PB_DEPTH    = 2 * MAX_SEQ_LEN;
   localparam int PB_AW       = $clog2(PB_DEPTH);
   localparam int CNT_W       = $clog2(PB_DEPTH + 1);
   localparam int SCORE_W     = 15;
   localparam int SUM_W       = SCORE_W + 2;
   localparam int CELL_MAX    = 32767;
   localparam int MATCH_W     = 17;
   localparam int IDX_W       = 8;
   localparam logic [7:0] GAP_CHAR = 8'd95;

   localparam logic [1:0] OP_FIRST  = 2'd0;
   localparam logic [1:0] OP_SECOND = 2'd1;
   localparam logic [1:0] OP_FETCH  = 2'd2;

   localparam logic [1:0] KIND_HDR = 2'd0;
   localparam logic [1:0] KIND_COL = 2'd1;
   localparam logic [1:0] KIND_END = 2'd2;

   localparam logic [1:0] CSR_MATCH    = 2'd0;
   localparam logic [1:0] CSR_MISMATCH = 2'd1;
   localparam logic [1:0] CSR_GAP      = 2'd2;

   typedef struct packed {
      logic ld_first;
      logic ld_second;
      logic fill_init;
      logic fill_rd;
      logic fill_calc;
      logic scan_rd;
      logic scan_chk;
      logic tb_cur;
      logic tb_diag;
      logic tb_up;
      logic tb_dec;
      logic emit_rd;
      logic out_hdr;
      logic out_col;
      logic out_end;
   } cmd_type;

   typedef struct packed {
      logic fill_empty;
      logic fill_last;
      logic scan_avail;
      logic scan_hit;
      logic scan_next;
      logic tb_done;
      logic emit_nz;
      logic out_free;
   } sts_type;
endpackage
`default_nettype wire

// ===== rtl/lsat_ram.sv =====
// Generic single-write, single-read RAM with registered read data.
`timescale 1ns / 1ps
`default_nettype none
module lsat_ram #(
   parameter int WIDTH = 8,
   parameter int DEPTH = 256
) (
   input  wire logic                     clock,
   input  wire logic                     wr_en,
   input  wire logic [$clog2(DEPTH)-1:0] wr_addr,
   input  wire logic [WIDTH-1:0]         wr_data,
   input  wire logic [$clog2(DEPTH)-1:0] rd_addr,
   output logic      [WIDTH-1:0]         rd_data
);
   logic [WIDTH-1:0] mem_ff [DEPTH];
   logic [WIDTH-1:0] rd_data_ff;

   always_ff @(posedge clock) begin
      if (wr_en) begin
         mem_ff[wr_addr] <= wr_data;
      end
      rd_data_ff <= mem_ff[rd_addr];
   end

   assign rd_data = rd_data_ff;
endmodule
`default_nettype wire

// ===== rtl/lsat_ctrl.sv =====
// Sequencer for loads, matrix fill, scan, traceback and result output.
`timescale 1ns / 1ps
`default_nettype none
module lsat_ctrl (
   input  wire logic             clock,
   input  wire logic             reset,
   input  wire logic             req_tvalid,
   output logic                  req_tready,
   input  wire logic [1:0]       req_tuser,
   input  wire logic             req_tlast,
   input  wire lsat_pkg::sts_type sts,
   output lsat_pkg::cmd_type     cmd
);
   typedef enum logic [13:0] {
      ST_IDLE      = 14'b00000000000001,
      ST_FILL_INIT = 14'b00000000000010,
      ST_FILL_RD   = 14'b00000000000100,
      ST_FILL_CALC = 14'b00000000001000,
      ST_SCAN_RD   = 14'b00000000010000,
      ST_SCAN_CHK  = 14'b00000000100000,
      ST_TB_CUR    = 14'b00000001000000,
      ST_TB_DIAG   = 14'b00000010000000,
      ST_TB_UP     = 14'b00000100000000,
      ST_TB_DEC    = 14'b00001000000000,
      ST_EMIT_RD   = 14'b00010000000000,
      ST_OUT_HDR   = 14'b00100000000000,
      ST_OUT_COL   = 14'b01000000000000,
      ST_OUT_END   = 14'b10000000000000
   } state_type;

   state_type state_ff, state_in;
   logic      accept;

   assign req_tready = (state_ff == ST_IDLE);
   assign accept     = req_tvalid && req_tready;

   always_comb begin
      state_in = state_ff;
      cmd      = '0;
      case (state_ff)
         ST_IDLE: begin
            if (accept) begin
               case (req_tuser)
                  lsat_pkg::OP_FIRST: cmd.ld_first = 1'b1;
                  lsat_pkg::OP_SECOND: begin
                     cmd.ld_second = 1'b1;
                     if (req_tlast) state_in = ST_FILL_INIT;
                  end
                  lsat_pkg::OP_FETCH: begin
                     if (sts.emit_nz) state_in = ST_EMIT_RD;
                     else if (sts.scan_avail) state_in = ST_SCAN_RD;
                     else state_in = ST_OUT_END;
                  end
                  default: ;
               endcase
            end
         end
         ST_FILL_INIT: begin
            cmd.fill_init = 1'b1;
            state_in = sts.fill_empty ? ST_IDLE : ST_FILL_RD;
         end
         ST_FILL_RD: begin
            cmd.fill_rd = 1'b1;
            state_in = ST_FILL_CALC;
         end
         ST_FILL_CALC: begin
            cmd.fill_calc = 1'b1;
            state_in = sts.fill_last ? ST_IDLE : ST_FILL_RD;
         end
         ST_SCAN_RD: begin
            cmd.scan_rd = 1'b1;
            state_in = ST_SCAN_CHK;
         end
         ST_SCAN_CHK: begin
            cmd.scan_chk = 1'b1;
            if (sts.scan_hit) state_in = ST_TB_CUR;
            else if (sts.scan_next) state_in = ST_SCAN_RD;
            else state_in = ST_OUT_END;
         end
         ST_TB_CUR: begin
            cmd.tb_cur = 1'b1;
            state_in = sts.tb_done ? ST_OUT_HDR : ST_TB_DIAG;
         end
         ST_TB_DIAG: begin
            cmd.tb_diag = 1'b1;
            state_in = ST_TB_UP;
         end
         ST_TB_UP: begin
            cmd.tb_up = 1'b1;
            state_in = ST_TB_DEC;
         end
         ST_TB_DEC: begin
            cmd.tb_dec = 1'b1;
            state_in = ST_TB_CUR;
         end
         ST_EMIT_RD: begin
            cmd.emit_rd = 1'b1;
            state_in = ST_OUT_COL;
         end
         ST_OUT_HDR: begin
            if (sts.out_free) begin
               cmd.out_hdr = 1'b1;
               state_in = ST_IDLE;
            end
         end
         ST_OUT_COL: begin
            if (sts.out_free) begin
               cmd.out_col = 1'b1;
               state_in = ST_IDLE;
            end
         end
         ST_OUT_END: begin
            if (sts.out_free) begin
               cmd.out_end = 1'b1;
               state_in = ST_IDLE;
            end
         end
         default: state_in = ST_IDLE;
      endcase
   end

   always_ff @(posedge clock) begin
      if (reset) state_ff <= ST_IDLE;
      else state_ff <= state_in;
   end
endmodule
`default_nettype wire

// ===== rtl/lsat_dp.sv =====
// Datapath: sequence and score memories, fill arithmetic, traceback, output register.
`timescale 1ns / 1ps
`default_nettype none
module lsat_dp (
   input  wire logic              clock,
   input  wire logic              reset,
   input  wire lsat_pkg::cmd_type cmd,
   output lsat_pkg::sts_type      sts,
   input  wire logic [7:0]        req_tdata,
   input  wire logic              req_tlast,
   input  wire logic              csr_valid,
   input  wire logic [1:0]        csr_index,
   input  wire logic [7:0]        csr_data,
   output logic                   rsp_tvalid,
   input  wire logic              rsp_tready,
   output logic [63:0]            rsp_tdata,
   output logic [1:0]             rsp_tuser,
   output logic                   rsp_tlast
);
   localparam int LW = lsat_pkg::LEN_W;
   localparam int MW = lsat_pkg::MAT_AW;
   localparam int SW = lsat_pkg::SCORE_W;
   localparam int XW = lsat_pkg::SUM_W;
   localparam int CW = lsat_pkg::CNT_W;

   // configuration and held scores
   logic signed [7:0] match_ff, match_in, mism_ff, mism_in, gap_ff, gap_in;
   logic signed [7:0] hm_ff, hm_in, hg_ff, hg_in;
   // sequences
   logic [LW-1:0] len1_ff, len1_in, len2_ff, len2_in, len1_eff, len2_eff;
   logic          closed1_ff, closed1_in, closed2_ff, closed2_in;
   // fill
   logic [LW-1:0] fi_ff, fi_in, fj_ff, fj_in;
   logic [MW-1:0] frow_ff, frow_in;
   logic [SW-1:0] diag_ff, diag_in, left_ff, left_in, best_ff, best_in, max_ff, max_in;
   // scan
   logic [LW-1:0] si_ff, si_in, sj_ff, sj_in;
   logic [MW-1:0] sbase_ff, sbase_in;
   logic [lsat_pkg::MATCH_W-1:0] matches_ff, matches_in;
   // traceback and readout
   logic [LW-1:0] d_ff, d_in, p_ff, p_in;
   logic [MW-1:0] tbase_ff, tbase_in;
   logic [CW-1:0] cnt_ff, cnt_in, emit_ff, emit_in;
   logic [SW-1:0] cur_ff, cur_in, tdiag_ff, tdiag_in;
   logic [7:0]    ca_ff, ca_in, cb_ff, cb_in, stop_ff, stop_in;
   // result register
   logic          rv_ff, rv_in, rl_ff, rl_in;
   logic [1:0]    rk_ff, rk_in;
   logic [63:0]   rd_ff, rd_in;

   // memory ports
   logic                       s1_we, s2_we;
   logic [lsat_pkg::SEQ_AW-1:0] s1_wa, s2_wa, s1_ra, s2_ra;
   logic [7:0]                 s1_q, s2_q;
   logic                       m_we;
   logic [MW-1:0]              m_wa, m_ra;
   logic [SW-1:0]              m_q, m_wd;
   logic                       pb_we;
   logic [lsat_pkg::PB_AW-1:0] pb_wa, pb_ra;
   logic [15:0]                pb_wd, pb_q;

   // fill arithmetic
   logic signed [XW-1:0] f_up, f_s, t_d, t_u, t_l, f_v;
   logic [SW-1:0]        f_v15, f_up15, best_nx;
   // traceback arithmetic
   logic [SW-1:0]        t_up15;
   logic signed [XW-1:0] tb_dsum, tb_usum;
   logic                 out_load;

   assign len1_eff = closed1_ff ? '0 : len1_ff;
   assign len2_eff = closed2_ff ? '0 : len2_ff;
   assign s1_we = cmd.ld_first && (len1_eff < LW'(lsat_pkg::MAX_SEQ_LEN));
   assign s2_we = cmd.ld_second && (len2_eff < LW'(lsat_pkg::MAX_SEQ_LEN));
   assign s1_wa = len1_eff[lsat_pkg::SEQ_AW-1:0];
   assign s2_wa = len2_eff[lsat_pkg::SEQ_AW-1:0];
   assign s1_ra = cmd.tb_cur ? lsat_pkg::SEQ_AW'(d_ff - LW'(1))
                             : lsat_pkg::SEQ_AW'(fi_ff - LW'(1));
   assign s2_ra = cmd.tb_cur ? lsat_pkg::SEQ_AW'(p_ff - LW'(1))
                             : lsat_pkg::SEQ_AW'(fj_ff - LW'(1));

   always_comb begin
      m_ra = sbase_ff + MW'(sj_ff);
      if (cmd.fill_rd) m_ra = frow_ff - MW'(lsat_pkg::DIM) + MW'(fj_ff);
      else if (cmd.tb_cur) m_ra = tbase_ff + MW'(p_ff);
      else if (cmd.tb_diag) m_ra = tbase_ff - MW'(lsat_pkg::DIM) + MW'(p_ff) - MW'(1);
      else if (cmd.tb_up) m_ra = tbase_ff - MW'(lsat_pkg::DIM) + MW'(p_ff);
   end

   // cell of the row above; row 0 is the zero border
   assign f_up15 = (fi_ff == LW'(1)) ? '0 : m_q;
   assign f_up   = $signed({2'b00, f_up15});
   assign f_s    = (s1_q == s2_q) ? XW'(match_ff) : XW'(hm_ff);
   assign t_d    = $signed({2'b00, diag_ff}) + f_s;
   assign t_u    = f_up + XW'(hg_ff);
   assign t_l    = $signed({2'b00, left_ff}) + XW'(hg_ff);

   always_comb begin
      f_v = '0;
      if (t_d > f_v) f_v = t_d;
      if (t_u > f_v) f_v = t_u;
      if (t_l > f_v) f_v = t_l;
      if (f_v > XW'(lsat_pkg::CELL_MAX)) f_v = XW'(lsat_pkg::CELL_MAX);
   end
   assign f_v15   = f_v[SW-1:0];
   assign best_nx = (f_v15 > best_ff) ? f_v15 : best_ff;

   assign m_we = cmd.fill_calc;
   assign m_wa = frow_ff + MW'(fj_ff);
   assign m_wd = f_v15;

   assign t_up15  = (d_ff == LW'(1)) ? '0 : m_q;
   assign tb_dsum = $signed({2'b00, tdiag_ff}) + XW'(hm_ff);
   assign tb_usum = $signed({2'b00, t_up15}) + XW'(hg_ff);

   assign pb_we = cmd.tb_dec;
   assign pb_wa = cnt_ff[lsat_pkg::PB_AW-1:0];
   assign pb_ra = cmd.emit_rd ? (emit_ff[lsat_pkg::PB_AW-1:0] - lsat_pkg::PB_AW'(1))
                              : emit_ff[lsat_pkg::PB_AW-1:0];

   always_comb begin
      pb_wd = {lsat_pkg::GAP_CHAR, cb_ff};
      if ((ca_ff == cb_ff) || (tb_dsum == $signed({2'b00, cur_ff}))) pb_wd = {ca_ff, cb_ff};
      else if (tb_usum == $signed({2'b00, cur_ff})) pb_wd = {ca_ff, lsat_pkg::GAP_CHAR};
   end

   assign out_load = cmd.out_hdr || cmd.out_col || cmd.out_end;

   always_comb begin
      match_in = match_ff;  mism_in = mism_ff;  gap_in = gap_ff;
      hm_in = hm_ff;  hg_in = hg_ff;
      len1_in = len1_ff;  len2_in = len2_ff;
      closed1_in = closed1_ff;  closed2_in = closed2_ff;
      fi_in = fi_ff;  fj_in = fj_ff;  frow_in = frow_ff;
      diag_in = diag_ff;  left_in = left_ff;  best_in = best_ff;  max_in = max_ff;
      si_in = si_ff;  sj_in = sj_ff;  sbase_in = sbase_ff;  matches_in = matches_ff;
      d_in = d_ff;  p_in = p_ff;  tbase_in = tbase_ff;  cnt_in = cnt_ff;  emit_in = emit_ff;
      cur_in = cur_ff;  tdiag_in = tdiag_ff;  ca_in = ca_ff;  cb_in = cb_ff;
      stop_in = stop_ff;
      rk_in = rk_ff;  rd_in = rd_ff;  rl_in = rl_ff;
      rv_in = rsp_tready ? 1'b0 : rv_ff;

      if (csr_valid) begin
         case (csr_index)
            lsat_pkg::CSR_MATCH:    match_in = csr_data;
            lsat_pkg::CSR_MISMATCH: mism_in  = csr_data;
            lsat_pkg::CSR_GAP:      gap_in   = csr_data;
            default: ;
         endcase
      end

      // any load abandons pending results
      if (cmd.ld_first || cmd.ld_second) begin
         max_in = '0;  si_in = LW'(1);  sj_in = LW'(1);
         sbase_in = MW'(lsat_pkg::DIM);  emit_in = '0;  matches_in = '0;
      end
      if (cmd.ld_first) begin
         len1_in = s1_we ? len1_eff + LW'(1) : len1_eff;
         closed1_in = req_tlast;
      end
      if (cmd.ld_second) begin
         len2_in = s2_we ? len2_eff + LW'(1) : len2_eff;
         closed2_in = req_tlast;
      end

      if (cmd.fill_init) begin
         fi_in = LW'(1);  fj_in = LW'(1);  frow_in = MW'(lsat_pkg::DIM);
         diag_in = '0;  left_in = '0;  best_in = '0;
         hm_in = mism_ff;  hg_in = gap_ff;
      end
      if (cmd.fill_calc) begin
         diag_in = f_up15;  left_in = f_v15;  best_in = best_nx;
         if (fj_ff == len2_ff) begin
            fj_in = LW'(1);  fi_in = fi_ff + LW'(1);
            frow_in = frow_ff + MW'(lsat_pkg::DIM);
            diag_in = '0;  left_in = '0;
            if (fi_ff == len1_ff) max_in = best_nx;
         end else begin
            fj_in = fj_ff + LW'(1);
         end
      end

      if (cmd.scan_chk) begin
         if (sj_ff == len2_ff) begin
            sj_in = LW'(1);  si_in = si_ff + LW'(1);
            sbase_in = sbase_ff + MW'(lsat_pkg::DIM);
         end else begin
            sj_in = sj_ff + LW'(1);
         end
         if (m_q == max_ff) begin
            matches_in = matches_ff + lsat_pkg::MATCH_W'(1);
            d_in = si_ff;  p_in = sj_ff;  tbase_in = sbase_ff;  cnt_in = '0;
            stop_in = 8'(sj_ff - LW'(1));
         end
      end

      if (cmd.tb_cur && sts.tb_done) emit_in = cnt_ff;
      if (cmd.tb_diag) begin
         cur_in = m_q;  ca_in = s1_q;  cb_in = s2_q;
      end
      if (cmd.tb_up) tdiag_in = ((d_ff == LW'(1)) || (p_ff == LW'(1))) ? '0 : m_q;
      if (cmd.tb_dec) begin
         cnt_in = cnt_ff + CW'(1);
         if ((ca_ff == cb_ff) || (tb_dsum == $signed({2'b00, cur_ff}))) begin
            d_in = d_ff - LW'(1);  p_in = p_ff - LW'(1);
            tbase_in = tbase_ff - MW'(lsat_pkg::DIM);
         end else if (tb_usum == $signed({2'b00, cur_ff})) begin
            d_in = d_ff - LW'(1);
            tbase_in = tbase_ff - MW'(lsat_pkg::DIM);
         end else begin
            p_in = p_ff - LW'(1);
         end
      end

      if (cmd.emit_rd) emit_in = emit_ff - CW'(1);

      if (out_load) begin
         rv_in = 1'b1;  rd_in = '0;  rl_in = 1'b0;
         rd_in[16:0] = matches_ff;
      end
      if (cmd.out_hdr) begin
         rk_in = lsat_pkg::KIND_HDR;
         rd_in[31:17] = max_ff;
         rd_in[39:32] = p_ff[7:0];
         rd_in[47:40] = stop_ff;
      end
      if (cmd.out_col) begin
         rk_in = lsat_pkg::KIND_COL;
         rd_in[55:48] = pb_q[15:8];
         rd_in[63:56] = pb_q[7:0];
         rl_in = (emit_ff == '0);
      end
      if (cmd.out_end) rk_in = lsat_pkg::KIND_END;
   end

   always_comb begin
      sts.fill_empty = (len1_ff == '0) || (len2_ff == '0);
      sts.fill_last  = (fi_ff == len1_ff) && (fj_ff == len2_ff);
      sts.scan_avail = (max_ff != '0) && (len2_ff != '0) && (si_ff <= len1_ff);
      sts.scan_hit   = (m_q == max_ff);
      sts.scan_next  = !((si_ff == len1_ff) && (sj_ff == len2_ff));
      sts.tb_done    = (d_ff == '0) || (p_ff == '0);
      sts.emit_nz    = (emit_ff != '0);
      sts.out_free   = !rv_ff || rsp_tready;
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         match_ff <= 8'sd2;  mism_ff <= -8'sd1;  gap_ff <= -8'sd1;
         hm_ff <= -8'sd1;  hg_ff <= -8'sd1;
         len1_ff <= '0;  len2_ff <= '0;  closed1_ff <= 1'b1;  closed2_ff <= 1'b1;
         max_ff <= '0;  si_ff <= LW'(1);  sj_ff <= LW'(1);
         sbase_ff <= MW'(lsat_pkg::DIM);  emit_ff <= '0;  matches_ff <= '0;
         rv_ff <= 1'b0;
      end else begin
         match_ff <= match_in;  mism_ff <= mism_in;  gap_ff <= gap_in;
         hm_ff <= hm_in;  hg_ff <= hg_in;
         len1_ff <= len1_in;  len2_ff <= len2_in;
         closed1_ff <= closed1_in;  closed2_ff <= closed2_in;
         max_ff <= max_in;  si_ff <= si_in;  sj_ff <= sj_in;
         sbase_ff <= sbase_in;  emit_ff <= emit_in;  matches_ff <= matches_in;
         rv_ff <= rv_in;
      end
      fi_ff <= fi_in;  fj_ff <= fj_in;  frow_ff <= frow_in;
      diag_ff <= diag_in;  left_ff <= left_in;  best_ff <= best_in;
      d_ff <= d_in;  p_ff <= p_in;  tbase_ff <= tbase_in;  cnt_ff <= cnt_in;
      cur_ff <= cur_in;  tdiag_ff <= tdiag_in;  ca_ff <= ca_in;  cb_ff <= cb_in;
      stop_ff <= stop_in;
      rk_ff <= rk_in;  rd_ff <= rd_in;  rl_ff <= rl_in;
   end

   lsat_ram #(.WIDTH(8), .DEPTH(lsat_pkg::MAX_SEQ_LEN)) u_seq1 (
      .clock(clock), .wr_en(s1_we), .wr_addr(s1_wa), .wr_data(req_tdata),
      .rd_addr(s1_ra), .rd_data(s1_q));
   lsat_ram #(.WIDTH(8), .DEPTH(lsat_pkg::MAX_SEQ_LEN)) u_seq2 (
      .clock(clock), .wr_en(s2_we), .wr_addr(s2_wa), .wr_data(req_tdata),
      .rd_addr(s2_ra), .rd_data(s2_q));
   lsat_ram #(.WIDTH(lsat_pkg::SCORE_W), .DEPTH(lsat_pkg::MAT_DEPTH)) u_mat (
      .clock(clock), .wr_en(m_we), .wr_addr(m_wa), .wr_data(m_wd),
      .rd_addr(m_ra), .rd_data(m_q));
   lsat_ram #(.WIDTH(16), .DEPTH(lsat_pkg::PB_DEPTH)) u_path (
      .clock(clock), .wr_en(pb_we), .wr_addr(pb_wa), .wr_data(pb_wd),
      .rd_addr(pb_ra), .rd_data(pb_q));

   assign rsp_tvalid = rv_ff;
   assign rsp_tdata  = rd_ff;
   assign rsp_tuser  = rk_ff;
   assign rsp_tlast  = rl_ff;
endmodule
`default_nettype wire

// ===== rtl/local_alignment_score_traceback.sv =====
// Top level of the local alignment engine with traceback readout.
// Loads take one beat each and are taken one per cycle while the engine is idle. The
// last character of the second sequence starts the matrix fill, which for each cell
// reads the score memory for the cell above, then computes and writes it; no beat is
// taken during the fill. A fetch that returns a column reads the path buffer, then
// loads the result register. A fetch that returns a header scans the matrix cell by
// cell, then traces back one column per step, as each step reads three cells through
// the single read port of the score memory. An end item is sent when nothing is left
// to scan. The result register lets loads go on while a result waits to be taken.
`timescale 1ns / 1ps
`default_nettype none
`include "local_alignment_score_traceback_assert.svh"
module local_alignment_score_traceback (
   input  wire logic        clock,
   input  wire logic        reset,
   input  wire logic        req_tvalid,
   output logic             req_tready,
   input  wire logic [7:0]  req_tdata,   // symbol
   input  wire logic [1:0]  req_tuser,   // opcode
   input  wire logic        req_tlast,   // final_symbol
   output logic             rsp_tvalid,
   input  wire logic        rsp_tready,
   // match_number[16:0], best_score[31:17], start_index[39:32],
   // stop_index[47:40], first_char[55:48], second_char[63:56]
   output logic [63:0]      rsp_tdata,
   output logic [1:0]       rsp_tuser,   // item_kind
   output logic             rsp_tlast,   // last_of_match
   input  wire logic        csr_valid,
   output logic             csr_ready,
   input  wire logic [1:0]  csr_index,
   input  wire logic [7:0]  csr_data
);
   lsat_pkg::cmd_type cmd;
   lsat_pkg::sts_type sts;

   assign csr_ready = 1'b1;

   lsat_ctrl u_ctrl (
      .clock(clock), .reset(reset),
      .req_tvalid(req_tvalid), .req_tready(req_tready),
      .req_tuser(req_tuser), .req_tlast(req_tlast),
      .sts(sts), .cmd(cmd));

   lsat_dp u_dp (
      .clock(clock), .reset(reset), .cmd(cmd), .sts(sts),
      .req_tdata(req_tdata), .req_tlast(req_tlast),
      .csr_valid(csr_valid), .csr_index(csr_index), .csr_data(csr_data),
      .rsp_tvalid(rsp_tvalid), .rsp_tready(rsp_tready),
      .rsp_tdata(rsp_tdata), .rsp_tuser(rsp_tuser), .rsp_tlast(rsp_tlast));

   // a header never carries a zero score
   `LSAT_ASSERT_NOW(a_hdr_score, rsp_tvalid && (rsp_tuser == lsat_pkg::KIND_HDR),
                    rsp_tdata[31:17] != '0)
   // only a column closes a match
   `LSAT_ASSERT_NOW(a_last_col, rsp_tvalid && rsp_tlast,
                    rsp_tuser == lsat_pkg::KIND_COL)
   // taking a request and the fill never overlap
   `LSAT_ASSERT_NEXT(a_fill_quiet, cmd.fill_calc && !sts.fill_last,
                     !req_tready)
endmodule
`default_nettype wire
